// ===== rtl/fsmff_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fsmff_pkg
// Shared types and constants of the free-space map first-fit block.
// ----------------------------------------------------------------------------
package fsmff_pkg;

  // Field widths of one beat on each channel
  localparam int unsigned INDEX_W = 16;
  localparam int unsigned BYTES_W = 16;
  localparam int unsigned PAGE_W  = 12;

  // Category entries and how many sit in one memory word
  localparam int unsigned CAT_W   = 8;
  localparam int unsigned LANES   = 8;
  localparam int unsigned LANE_W  = 3;
  localparam int unsigned WORD_W  = LANES * CAT_W;

  localparam logic [CAT_W-1:0] CAT_MAX = 8'd255;

  // Fixed-point reciprocal used to quantize byte counts
  localparam int unsigned RECIP_SHIFT = 28;
  localparam int unsigned RECIP_W     = RECIP_SHIFT + 1;
  localparam int unsigned GRAN_W      = 13;

  typedef enum logic [0:0] {
    OP_UPDATE = 1'b0,
    OP_FIND   = 1'b1
  } opcode_t;

  // Result of matching one memory word against a needed category
  typedef struct packed {
    logic              hit;
    logic [LANE_W-1:0] lane;
  } match_t;

endpackage

// ===== rtl/fsmff_if.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fsmff_req_if / fsmff_rsp_if
// Valid/ready channels carrying request and result beats.
// ----------------------------------------------------------------------------
interface fsmff_req_if;
  logic                                 valid;
  logic                                 ready;
  fsmff_pkg::opcode_t                   opcode;
  logic [fsmff_pkg::INDEX_W-1:0]        page_index;
  logic [fsmff_pkg::BYTES_W-1:0]        byte_count;

  modport source (output valid, output opcode, output page_index, output byte_count,
                  input ready);
  modport sink   (input valid, input opcode, input page_index, input byte_count,
                  output ready);
endinterface

interface fsmff_rsp_if;
  logic                                 valid;
  logic                                 ready;
  logic                                 found;
  logic [fsmff_pkg::PAGE_W-1:0]         found_page;

  modport source (output valid, output found, output found_page, input ready);
  modport sink   (input valid, input found, input found_page, output ready);
endinterface

// ===== rtl/fsmff_cat_ram.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fsmff_cat_ram
// Category memory: one word holds a row of byte categories, with a byte-lane
// write mask and a registered read port.
// ----------------------------------------------------------------------------
module fsmff_cat_ram #(
  parameter int unsigned WORDS  = 512,
  parameter int unsigned ADDR_W = 9
) (
  input  logic                             clk,
  input  logic                             wr_en,
  input  logic [ADDR_W-1:0]                wr_addr,
  input  logic [fsmff_pkg::LANES-1:0]      wr_mask,
  input  logic [fsmff_pkg::WORD_W-1:0]     wr_data,
  input  logic                             rd_en,
  input  logic [ADDR_W-1:0]                rd_addr,
  output logic [fsmff_pkg::WORD_W-1:0]     rd_data
);
  import fsmff_pkg::*;

  logic [WORD_W-1:0] mem [WORDS];

  // Write the enabled byte lanes
  always_ff @(posedge clk) begin
    if (wr_en) begin
      for (int i = 0; i < LANES; i++) begin
        if (wr_mask[i]) begin
          mem[wr_addr][i*CAT_W +: CAT_W] <= wr_data[i*CAT_W +: CAT_W];
        end
      end
    end
  end

  // Register the read word
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

// ===== rtl/fsmff_lane_match.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fsmff_lane_match
// Compare every category of one memory word with the needed category and
// pick the lowest lane that is nonzero and large enough.
// ----------------------------------------------------------------------------
module fsmff_lane_match (
  input  logic [fsmff_pkg::WORD_W-1:0] word,
  input  logic [fsmff_pkg::CAT_W-1:0]  need,
  output fsmff_pkg::match_t            result
);
  import fsmff_pkg::*;

  logic [LANES-1:0] ok;

  // Flag each lane that satisfies the request
  always_comb begin
    for (int i = 0; i < LANES; i++) begin
      ok[i] = (word[i*CAT_W +: CAT_W] >= need) && (word[i*CAT_W +: CAT_W] != '0);
    end
  end

  // Priority toward the lowest lane
  always_comb begin
    result.hit  = |ok;
    result.lane = '0;
    for (int i = LANES - 1; i >= 0; i--) begin
      if (ok[i]) begin
        result.lane = LANE_W'(i);
      end
    end
  end

endmodule

// ===== rtl/free_space_map_first_fit.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// free_space_map_first_fit
// Free-space map with a first-fit page search over a category memory.
// ----------------------------------------------------------------------------
// Usage:
//   req carries one beat per operation: opcode OP_UPDATE stores the category
//   of byte_count (byte_count / GRANULE_BYTES, capped at 255) for page_index;
//   indices at or above ENTRIES are dropped. OP_FIND quantizes byte_count the
//   same way and returns on rsp the lowest page whose category is nonzero and
//   at least the needed one, or found = 0 with found_page = 0.
//   One beat is worked on at a time. An update passes S_MUL, S_FIX and S_WRITE
//   before req.ready rises again. A find passes S_MUL and S_FIX, then the scan
//   reads one memory word of eight categories per cycle and stops at the first
//   word with a hit or at the last word.
//   The result sits in an output register. While rsp.ready is low the block
//   holds that beat and still takes requests; once a second search has
//   finished, req.ready stays low until the held beat is delivered.
//   After rst the block clears the memory, one word per cycle; req.ready
//   stays low during that pass.
// ----------------------------------------------------------------------------
module free_space_map_first_fit #(
  parameter int unsigned ENTRIES       = 4096,
  parameter int unsigned GRANULE_BYTES = 32
) (
  input  logic        clk,
  input  logic        rst,
  fsmff_req_if.sink   req,
  fsmff_rsp_if.source rsp
);
  import fsmff_pkg::*;

  localparam int unsigned WORDS  = (ENTRIES + LANES - 1) / LANES;
  localparam int unsigned ADDR_W = (WORDS > 1) ? $clog2(WORDS) : 1;
  localparam logic [ADDR_W-1:0]   LAST_WORD = ADDR_W'(WORDS - 1);
  localparam logic [INDEX_W:0]    ENTRY_LIM = (INDEX_W + 1)'(ENTRIES);
  localparam logic [RECIP_W-1:0]  RECIP     = RECIP_W'((64'd1 << RECIP_SHIFT) / GRANULE_BYTES);
  localparam logic [GRAN_W-1:0]   GRAN      = GRAN_W'(GRANULE_BYTES);

  typedef enum logic [5:0] {
    S_CLEAR = 6'b000001,
    S_IDLE  = 6'b000010,
    S_MUL   = 6'b000100,
    S_FIX   = 6'b001000,
    S_WRITE = 6'b010000,
    S_SCAN  = 6'b100000
  } state_t;

  state_t                    state;
  logic                      done_pending;
  logic [ADDR_W-1:0]         clr_addr;
  logic [ADDR_W-1:0]         word_addr;
  opcode_t                   op_r;
  logic [INDEX_W-1:0]        idx_r;
  logic [BYTES_W-1:0]        bytes_r;
  logic                      in_range_r;
  logic [BYTES_W-1:0]        quot0;
  logic [CAT_W-1:0]          cat;
  logic                      res_found;
  logic [PAGE_W-1:0]         res_page;
  logic                      out_valid;
  logic                      out_found;
  logic [PAGE_W-1:0]         out_page;

  logic [BYTES_W+RECIP_W-1:0]           prod;
  logic [BYTES_W+GRAN_W-1:0]            back;
  logic [BYTES_W+GRAN_W-1:0]            rem;
  logic [BYTES_W:0]                     quot;
  logic                                 wr_en;
  logic [ADDR_W-1:0]                    wr_addr;
  logic [LANES-1:0]                     wr_mask;
  logic [WORD_W-1:0]                    wr_data;
  logic                                 rd_en;
  logic [ADDR_W-1:0]                    rd_addr;
  logic [WORD_W-1:0]                    rd_data;
  match_t                               match;
  logic [PAGE_W+ADDR_W+LANE_W-1:0]      hit_ext;
  logic                                 out_free;

  // Quantize: reciprocal multiply, then one correction step
  assign prod = BYTES_W'(bytes_r) * RECIP;
  assign back = quot0 * GRAN;
  assign rem  = (BYTES_W + GRAN_W)'(bytes_r) - back;
  assign quot = {1'b0, quot0} + (BYTES_W + 1)'(rem >= (BYTES_W + GRAN_W)'(GRAN));

  // Memory port selection
  always_comb begin
    wr_en   = 1'b0;
    wr_addr = clr_addr;
    wr_mask = '1;
    wr_data = '0;
    case (state)
      S_CLEAR: begin
        wr_en = 1'b1;
      end
      S_WRITE: begin
        wr_en   = in_range_r;
        wr_addr = ADDR_W'(idx_r >> LANE_W);
        wr_mask = LANES'(1) << idx_r[LANE_W-1:0];
        wr_data = {LANES{cat}};
      end
      default: begin
        wr_en = 1'b0;
      end
    endcase
  end

  always_comb begin
    rd_en   = 1'b0;
    rd_addr = '0;
    case (state)
      S_FIX: begin
        rd_en = 1'b1;
      end
      S_SCAN: begin
        rd_en   = 1'b1;
        rd_addr = (word_addr == LAST_WORD) ? word_addr : word_addr + 1'b1;
      end
      default: begin
        rd_en = 1'b0;
      end
    endcase
  end

  fsmff_cat_ram #(
    .WORDS  (WORDS),
    .ADDR_W (ADDR_W)
  ) u_ram (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_mask (wr_mask),
    .wr_data (wr_data),
    .rd_en   (rd_en),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  fsmff_lane_match u_match (
    .word   (rd_data),
    .need   (cat),
    .result (match)
  );

  assign hit_ext  = {PAGE_W'(0), word_addr, match.lane};
  assign out_free = !out_valid || rsp.ready;
  assign req.ready = (state == S_IDLE) && !done_pending;

  // Sequencer: clear, quantize, then write or scan
  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= S_CLEAR;
      clr_addr     <= '0;
      done_pending <= 1'b0;
    end else begin
      case (state)
        S_CLEAR: begin
          clr_addr <= clr_addr + 1'b1;
          if (clr_addr == LAST_WORD) begin
            state <= S_IDLE;
          end
        end
        S_IDLE: begin
          if (done_pending) begin
            if (out_free) begin
              done_pending <= 1'b0;
            end
          end else if (req.valid) begin
            state <= S_MUL;
          end
        end
        S_MUL: begin
          state <= S_FIX;
        end
        S_FIX: begin
          state <= (op_r == OP_FIND) ? S_SCAN : S_WRITE;
        end
        S_WRITE: begin
          state <= S_IDLE;
        end
        S_SCAN: begin
          if (match.hit || word_addr == LAST_WORD) begin
            state        <= S_IDLE;
            done_pending <= 1'b1;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  // Capture the request beat and the datapath values
  always_ff @(posedge clk) begin
    if (req.valid && req.ready) begin
      op_r       <= req.opcode;
      idx_r      <= req.page_index;
      bytes_r    <= req.byte_count;
      in_range_r <= {1'b0, req.page_index} < ENTRY_LIM;
    end
    if (state == S_MUL) begin
      quot0 <= prod[RECIP_SHIFT +: BYTES_W];
    end
    if (state == S_FIX) begin
      cat       <= (quot > (BYTES_W + 1)'(CAT_MAX)) ? CAT_MAX : quot[CAT_W-1:0];
      word_addr <= '0;
    end else if (state == S_SCAN) begin
      if (!match.hit && word_addr != LAST_WORD) begin
        word_addr <= word_addr + 1'b1;
      end
    end
    if (state == S_SCAN) begin
      res_found <= match.hit;
      res_page  <= match.hit ? hit_ext[PAGE_W-1:0] : '0;
    end
  end

  // Output register: load a finished result, drop it when taken
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (state == S_IDLE && done_pending && out_free) begin
      out_valid <= 1'b1;
    end else if (rsp.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (state == S_IDLE && done_pending && out_free) begin
      out_found <= res_found;
      out_page  <= res_page;
    end
  end

  assign rsp.valid      = out_valid;
  assign rsp.found      = out_found;
  assign rsp.found_page = out_page;

`ifndef ASSERT_OFF
  a_no_write_in_scan: assert property (@(posedge clk) disable iff (rst)
    (state == S_SCAN) |-> !wr_en)
    else $error("memory write during a scan");

  a_scan_in_bounds: assert property (@(posedge clk) disable iff (rst)
    (state == S_SCAN) |-> (word_addr <= LAST_WORD))
    else $error("scan address beyond the last word");

  a_accept_starts: assert property (@(posedge clk) disable iff (rst)
    (req.valid && req.ready) |=> (state == S_MUL))
    else $error("accepted beat did not start quantization");

  a_miss_page_zero: assert property (@(posedge clk) disable iff (rst)
    (rsp.valid && !rsp.found) |-> (rsp.found_page == '0))
    else $error("not-found result carries a nonzero page");

  a_result_from_done: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(done_pending))
    else $error("result raised without a finished scan");
`endif

endmodule

// ===== tb/sv/free_space_map_first_fit_tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// free_space_map_first_fit_tb
// Self-checking bench for the free-space map first-fit search. A short
// directed table walks the empty map, dropped out-of-range updates,
// saturation and the rule that empty pages never match. Randomized bursts
// then fill page windows up to a category ceiling and search around it,
// with occasional sweeps that empty the map again. Search results are checked
// against the local category map copy or a typed directed row. Both channels
// stall at random rates except in the last phase; one long result hold is added.
// ----------------------------------------------------------------------------
module free_space_map_first_fit_tb;
  import fsmff_pkg::*;

  localparam int unsigned ENTRIES       = 4096;
  localparam int unsigned GRANULE_BYTES = 32;
  localparam int unsigned RANDOM_ITEMS  = 1145;
  localparam int unsigned DRAIN_CYCLES  = 600;
  localparam int unsigned HOLD_CYCLES   = 600;
  localparam int unsigned HOLD_AT_BEAT  = 60;
  localparam int unsigned LIMIT_CYCLES  = 3_000_000;

  typedef struct packed {
    opcode_t             op;
    logic [INDEX_W-1:0]  page;
    logic [BYTES_W-1:0]  bytes;
  } req_beat_t;

  typedef struct packed {
    logic              found;
    logic [PAGE_W-1:0] page;
  } find_result_t;

  typedef struct packed {
    opcode_t             op;
    logic [INDEX_W-1:0]  page;
    logic [BYTES_W-1:0]  bytes;
    logic                typed;
    logic                found;
    logic [PAGE_W-1:0]   found_page;
  } directed_row_t;

  // Directed walk; typed rows carry their result, the rest use the map copy
  localparam directed_row_t DIRECTED [25] = '{
    '{OP_FIND,   16'h0000, 16'h0000, 1'b1, 1'b0, 12'd0},     // empty after reset
    '{OP_FIND,   16'hFFFF, 16'hFFFF, 1'b1, 1'b0, 12'd0},
    '{OP_UPDATE, 16'hFFFF, 16'hFFFF, 1'b0, 1'b0, 12'd0},     // out of range
    '{OP_UPDATE, 16'd4096, 16'hFFFF, 1'b0, 1'b0, 12'd0},     // first index past the map
    '{OP_FIND,   16'h0000, 16'h0000, 1'b1, 1'b0, 12'd0},     // still empty
    '{OP_UPDATE, 16'd4095, 16'hFFFF, 1'b0, 1'b0, 12'd0},
    '{OP_FIND,   16'h0000, 16'hFFFF, 1'b1, 1'b1, 12'd4095},
    '{OP_UPDATE, 16'h0000, 16'd31,   1'b0, 1'b0, 12'd0},     // rounds to empty
    '{OP_FIND,   16'h0000, 16'h0000, 1'b1, 1'b1, 12'd4095},  // empty page skipped
    '{OP_UPDATE, 16'h0000, 16'd32,   1'b0, 1'b0, 12'd0},
    '{OP_FIND,   16'h0000, 16'd32,   1'b0, 1'b0, 12'd0},
    '{OP_FIND,   16'h0000, 16'd64,   1'b0, 1'b0, 12'd0},
    '{OP_UPDATE, 16'd7,    16'd8191, 1'b0, 1'b0, 12'd0},
    '{OP_UPDATE, 16'd8,    16'd8192, 1'b0, 1'b0, 12'd0},     // saturates
    '{OP_FIND,   16'h0000, 16'hFFFF, 1'b0, 1'b0, 12'd0},
    '{OP_UPDATE, 16'd7,    16'h0000, 1'b0, 1'b0, 12'd0},
    '{OP_FIND,   16'h0000, 16'd8160, 1'b0, 1'b0, 12'd0},
    '{OP_UPDATE, 16'h0AAA, 16'h5555, 1'b0, 1'b0, 12'd0},
    '{OP_UPDATE, 16'h0555, 16'hAAAA, 1'b0, 1'b0, 12'd0},
    '{OP_UPDATE, 16'd4095, 16'h0000, 1'b0, 1'b0, 12'd0},
    '{OP_UPDATE, 16'd8,    16'h0000, 1'b0, 1'b0, 12'd0},
    '{OP_UPDATE, 16'h0000, 16'h0000, 1'b0, 1'b0, 12'd0},
    '{OP_UPDATE, 16'h0AAA, 16'h0000, 1'b0, 1'b0, 12'd0},
    '{OP_UPDATE, 16'h0555, 16'h001F, 1'b0, 1'b0, 12'd0},
    '{OP_FIND,   16'hAAAA, 16'h0000, 1'b1, 1'b0, 12'd0}      // emptied again
  };

  logic clk;
  logic rst;

  fsmff_req_if req_ch ();
  fsmff_rsp_if rsp_ch ();

  free_space_map_first_fit #(
    .ENTRIES       (ENTRIES),
    .GRANULE_BYTES (GRANULE_BYTES)
  ) u_dut (
    .clk (clk),
    .rst (rst),
    .req (req_ch),
    .rsp (rsp_ch)
  );

  // Local copy of the category map and the searches still owed a result
  logic [CAT_W-1:0] page_cats [ENTRIES];
  find_result_t     pending_finds [$];

  int unsigned tx_idle_pct;
  int unsigned rx_idle_pct;
  int unsigned n_updates;
  int unsigned n_dropped;
  int unsigned n_hits;
  int unsigned n_misses;
  int unsigned n_checked;
  int unsigned n_errors;
  int unsigned hold_left;
  int unsigned cycle_cnt;

  function automatic logic [CAT_W-1:0] quantize_bytes(logic [BYTES_W-1:0] bytes);
    int unsigned q;
    q = bytes / GRANULE_BYTES;
    if (q > CAT_MAX) begin
      q = CAT_MAX;
    end
    return q[CAT_W-1:0];
  endfunction

  // Lowest nonzero entry at or above the needed category
  function automatic find_result_t first_fit_lookup(logic [CAT_W-1:0] need);
    find_result_t res;
    res = '0;
    for (int i = ENTRIES - 1; i >= 0; i--) begin
      if (page_cats[i] != '0 && page_cats[i] >= need) begin
        res.found = 1'b1;
        res.page  = i[PAGE_W-1:0];
      end
    end
    return res;
  endfunction

  // One beat of a fill-and-search burst around a category ceiling
  function automatic req_beat_t burst_beat(int unsigned ceil_cat, int unsigned base);
    req_beat_t   b;
    int unsigned roll;
    roll    = $urandom_range(99);
    b.op    = opcode_t'($urandom_range(1));
    b.page  = 16'($urandom_range(65535));
    b.bytes = 16'($urandom_range(65535));
    if (roll >= 10 && roll < 55) begin
      b.op   = OP_UPDATE;
      b.page = 16'(base + $urandom_range(31));
      if ($urandom_range(19) == 0) begin
        b.bytes = 16'($urandom_range(GRANULE_BYTES - 1));
      end else if (ceil_cat == CAT_MAX && $urandom_range(1) == 1) begin
        b.bytes = 16'($urandom_range(65535, CAT_MAX * GRANULE_BYTES));
      end else begin
        b.bytes = 16'($urandom_range(ceil_cat * GRANULE_BYTES + GRANULE_BYTES - 1));
      end
    end else if (roll >= 55) begin
      b.op    = OP_FIND;
      b.bytes = 16'($urandom_range((ceil_cat + 2) * GRANULE_BYTES));
    end
    return b;
  endfunction

  // Offer one beat after a random gap, then fold it into the map copy
  task automatic send_request(input req_beat_t beat, input logic typed,
                              input find_result_t typed_res);
    find_result_t res;
    while ($urandom_range(99) < tx_idle_pct) begin
      req_ch.valid <= 1'b0;
      @(posedge clk);
    end
    req_ch.valid      <= 1'b1;
    req_ch.opcode     <= beat.op;
    req_ch.page_index <= beat.page;
    req_ch.byte_count <= beat.bytes;
    do @(posedge clk); while (req_ch.ready !== 1'b1);
    if (beat.op == OP_UPDATE) begin
      n_updates++;
      if (beat.page < ENTRIES) begin
        page_cats[beat.page[PAGE_W-1:0]] = quantize_bytes(beat.bytes);
      end else begin
        n_dropped++;
      end
    end else begin
      res = typed ? typed_res : first_fit_lookup(quantize_bytes(beat.bytes));
      if (res.found) begin
        n_hits++;
      end else begin
        n_misses++;
      end
      pending_finds.push_back(res);
    end
  endtask

  // Clock
  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  // Abort a hung run
  initial begin
    cycle_cnt = 0;
    forever begin
      @(posedge clk);
      cycle_cnt++;
      if (cycle_cnt >= LIMIT_CYCLES) begin
        $display("timeout after %0d cycles, %0d results outstanding",
                 cycle_cnt, pending_finds.size());
        $display("SCOREBOARD MISMATCH");
        $finish;
      end
    end
  end

  // Result side: check each beat, drive ready with random stalls
  initial begin
    find_result_t want;
    hold_left    = 0;
    n_checked    = 0;
    n_errors     = 0;
    rsp_ch.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (!rst && rsp_ch.valid === 1'b1 && rsp_ch.ready === 1'b1) begin
        n_checked++;
        if (pending_finds.size() == 0) begin
          $error("result beat with no search pending: found=%0b found_page=%0d",
                 rsp_ch.found, rsp_ch.found_page);
          n_errors++;
        end else begin
          want = pending_finds.pop_front();
          if (rsp_ch.found !== want.found) begin
            $error("found: expected %0b, actual %0b", want.found, rsp_ch.found);
            n_errors++;
          end
          if (rsp_ch.found_page !== want.page) begin
            $error("found_page: expected %0d, actual %0d", want.page, rsp_ch.found_page);
            n_errors++;
          end
        end
        // back up the block behind a held result
        if (n_checked == HOLD_AT_BEAT) begin
          hold_left = HOLD_CYCLES;
        end
      end
      if (hold_left != 0) begin
        rsp_ch.ready <= 1'b0;
        hold_left--;
      end else begin
        rsp_ch.ready <= ($urandom_range(99) >= rx_idle_pct);
      end
    end
  end

  // Request side: reset, directed table, then randomized bursts
  initial begin
    req_beat_t    beat;
    find_result_t typed_res;
    int unsigned  sent;
    int unsigned  phase;
    int unsigned  ceil_cat;
    int unsigned  base;
    int unsigned  burst_len;

    tx_idle_pct = 18;
    rx_idle_pct = 64;
    n_updates   = 0;
    n_dropped   = 0;
    n_hits      = 0;
    n_misses    = 0;
    for (int i = 0; i < ENTRIES; i++) begin
      page_cats[i] = '0;
    end
    rst               <= 1'b1;
    req_ch.valid      <= 1'b0;
    req_ch.opcode     <= OP_UPDATE;
    req_ch.page_index <= '0;
    req_ch.byte_count <= '0;
    repeat (7) @(posedge clk);
    rst <= 1'b0;

    foreach (DIRECTED[r]) begin
      beat.op          = DIRECTED[r].op;
      beat.page        = DIRECTED[r].page;
      beat.bytes       = DIRECTED[r].bytes;
      typed_res.found  = DIRECTED[r].found;
      typed_res.page   = DIRECTED[r].found_page;
      send_request(beat, DIRECTED[r].typed, typed_res);
    end

    sent  = 0;
    phase = 1;
    while (sent < RANDOM_ITEMS) begin
      // switch stall profile; drain fully before the second one
      if (phase == 1 && sent >= RANDOM_ITEMS / 3) begin
        req_ch.valid <= 1'b0;
        do @(posedge clk); while (pending_finds.size() != 0);
        phase       = 2;
        tx_idle_pct = 64;
        rx_idle_pct = 18;
      end else if (phase == 2 && sent >= 2 * RANDOM_ITEMS / 3) begin
        phase       = 3;
        tx_idle_pct = 0;
        rx_idle_pct = 0;
      end

      // sometimes empty every occupied page so searches can miss again
      if ($urandom_range(99) < 40) begin
        for (int i = 0; i < ENTRIES; i++) begin
          if (page_cats[i] != '0) begin
            beat.op    = OP_UPDATE;
            beat.page  = 16'(i);
            beat.bytes = 16'($urandom_range(GRANULE_BYTES - 1));
            send_request(beat, 1'b0, '0);
            sent++;
          end
        end
      end

      ceil_cat  = $urandom_range(CAT_MAX, 1);
      base      = ($urandom_range(99) < 70) ? $urandom_range(255)
                                            : $urandom_range(ENTRIES - 32);
      burst_len = $urandom_range(32, 8);
      repeat (burst_len) begin
        beat = burst_beat(ceil_cat, base);
        send_request(beat, 1'b0, '0);
        sent++;
      end
    end

    // drain, then allow one worst-case search for stray beats
    req_ch.valid <= 1'b0;
    do @(posedge clk); while (pending_finds.size() != 0);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("covered %0d updates (%0d beyond the map) and %0d searches (%0d hits, %0d misses)",
             n_updates, n_dropped, n_hits + n_misses, n_hits, n_misses);
    $display("checked %0d result beats in %0d cycles, %0d errors",
             n_checked, cycle_cnt, n_errors);
    if (n_errors == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule

// ===== free_space_map_first_fit.f =====
rtl/fsmff_pkg.sv
rtl/fsmff_if.sv
rtl/fsmff_cat_ram.sv
rtl/fsmff_lane_match.sv
rtl/free_space_map_first_fit.sv
tb/sv/free_space_map_first_fit_tb.sv
